FILE: hw/rtl/dtp_pkg.sv
`timescale 1ns / 1ps
package dtp_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_SIZES = 3'd3,
		ST_NO_EXT    = 3'd4,
		ST_BAD_DIMS  = 3'd5
	} dtp_status_t;

	typedef struct packed {
		logic [31:0] file_word;
		logic        end_of_file;
	} dtp_word_t;

	typedef struct packed {
		dtp_status_t        status;
		logic [16:0]        image_width;
		logic [16:0]        image_height;
		logic signed [31:0] volume_depth;
		logic [30:0]        mip_levels;
		logic signed [31:0] array_layers;
		logic               cube_map;
		logic               volume_texture;
		logic               extended_header;
		logic [31:0]        format_code;
		logic signed [31:0] bits_per_pixel;
		logic               srgb;
	} dtp_result_t;

	localparam logic [5:0] POS_MAGIC     = 6'd0;
	localparam logic [5:0] POS_HDR_SIZE  = 6'd1;
	localparam logic [5:0] POS_HEIGHT    = 6'd3;
	localparam logic [5:0] POS_WIDTH     = 6'd4;
	localparam logic [5:0] POS_DEPTH     = 6'd6;
	localparam logic [5:0] POS_MIPS      = 6'd7;
	localparam logic [5:0] POS_PF_SIZE   = 6'd19;
	localparam logic [5:0] POS_PF_FLAGS  = 6'd20;
	localparam logic [5:0] POS_FOURCC    = 6'd21;
	localparam logic [5:0] POS_BIT_COUNT = 6'd22;
	localparam logic [5:0] POS_CAPS2     = 6'd28;
	localparam logic [5:0] POS_LAST_HDR  = 6'd31;
	localparam logic [5:0] POS_DXGI      = 6'd32;
	localparam logic [5:0] POS_MISC      = 6'd34;
	localparam logic [5:0] POS_ARRAY     = 6'd35;
	localparam logic [5:0] POS_LAST_EXT  = 6'd36;
	localparam logic [5:0] POS_MAX       = 6'd63;

	localparam logic [31:0] MAGIC_DDS    = 32'h2053_4444;
	localparam logic [31:0] CC_DX10      = 32'h3031_5844;
	localparam logic [31:0] HDR_SIZE     = 32'd124;
	localparam logic [31:0] PF_SIZE      = 32'd32;
	localparam logic [31:0] MAX_DIM      = 32'd65536;

	localparam logic [31:0] CC_DXT1 = 32'h3154_5844;
	localparam logic [31:0] CC_DXT2 = 32'h3254_5844;
	localparam logic [31:0] CC_DXT3 = 32'h3354_5844;
	localparam logic [31:0] CC_DXT4 = 32'h3454_5844;
	localparam logic [31:0] CC_DXT5 = 32'h3554_5844;
	localparam logic [31:0] CC_ATI1 = 32'h3149_5441;
	localparam logic [31:0] CC_ATI2 = 32'h3249_5441;
	localparam logic [31:0] CC_BC4U = 32'h5534_4342;
	localparam logic [31:0] CC_BC4S = 32'h5334_4342;
	localparam logic [31:0] CC_BC5U = 32'h5535_4342;
	localparam logic [31:0] CC_BC5S = 32'h5335_4342;

	function automatic logic [7:0] bpp_dxgi(input logic [31:0] f);
		logic [7:0] r;
		case (f) inside
			32'd2: r = 8'd128;
			32'd10, 32'd11: r = 8'd64;
			32'd16, 32'd24, 32'd25, 32'd26, 32'd28, 32'd29, 32'd30, 32'd31,
			32'd40, 32'd41, 32'd65, 32'd87, 32'd88, 32'd91, 32'd93: r = 8'd32;
			32'd34, 32'd49, 32'd50, 32'd54, 32'd56, 32'd85, 32'd86, 32'd115: r = 8'd16;
			32'd61: r = 8'd8;
			32'd71, 32'd72, 32'd80, 32'd81: r = 8'd4;
			32'd74, 32'd75, 32'd77, 32'd78,
			32'd83, 32'd84, 32'd95, 32'd96, 32'd98, 32'd99: r = 8'd8;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] bpp_fourcc(input logic [31:0] c);
		logic [7:0] r;
		case (c) inside
			CC_DXT1, CC_ATI1, CC_BC4U, CC_BC4S: r = 8'd4;
			CC_DXT2, CC_DXT3, CC_DXT4, CC_DXT5, CC_ATI2, CC_BC5U, CC_BC5S: r = 8'd8;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_srgb(input logic [31:0] f);
		return (f == 32'd29) || (f == 32'd72) || (f == 32'd75) || (f == 32'd78) ||
			(f == 32'd91) || (f == 32'd93) || (f == 32'd99);
	endfunction

endpackage

FILE: hw/rtl/dtp_word_if.sv
`timescale 1ns / 1ps
interface dtp_word_if import dtp_pkg::*; ();
	logic      valid;
	logic      ready;
	dtp_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/dtp_result_if.sv
`timescale 1ns / 1ps
interface dtp_result_if import dtp_pkg::*; ();
	logic        valid;
	logic        ready;
	dtp_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/dds_texture_header_parser_top.sv
`timescale 1ns / 1ps
// Parses a DDS texture file delivered as 32-bit little-endian words, one word per beat,
// with end_of_file set on the last word. A new word may follow in every cycle while ready is
// high; the result, once the header (word 31) or the DX10 extension (word 36) has been
// seen, or an error on an early end, appears on the result channel in the cycle after
// the deciding word is accepted. One result register holds it, and word beats
// keep flowing while it waits unless the result sink is stalling and the register is
// full. At most one result is given per file; the end_of_file beat always rearms the
// parser for the next file.
module dds_texture_header_parser_top import dtp_pkg::*; (
	input logic clk,
	input logic arst_n,
	dtp_word_if.sink words,
	dtp_result_if.source result
);

	logic [5:0]  pos_q;
	logic        given_q;
	logic        res_valid_q;
	dtp_result_t res_q;

	logic        magic_q;
	logic        sizes_q;
	logic [31:0] height_q;
	logic [31:0] width_q;
	logic [31:0] depth_q;
	logic [31:0] mips_q;
	logic [1:0]  caps_q;
	logic        fcc_flag_q;
	logic [31:0] fourcc_q;
	logic [31:0] bit_count_q;
	logic [31:0] dxgi_q;
	logic        cube_misc_q;
	logic [31:0] array_q;

	logic        accept;
	logic [31:0] w;
	logic        eof;
	logic        fire;
	logic        use_done;
	dtp_status_t code;
	logic        ext;
	logic        dims_bad;
	dtp_result_t res_d;

	assign accept = words.valid && words.ready;
	assign w = words.data.file_word;
	assign eof = words.data.end_of_file;
	assign words.ready = !res_valid_q || result.ready;
	assign result.valid = res_valid_q;
	assign result.data = res_q;

	assign ext = fcc_flag_q && (fourcc_q == CC_DX10);
	assign dims_bad = (width_q == 32'd0) || (width_q > MAX_DIM) ||
		(height_q == 32'd0) || (height_q > MAX_DIM);

	always_comb begin
		fire = 1'b0;
		use_done = 1'b0;
		code = ST_OK;
		if (!given_q) begin
			if (pos_q == POS_LAST_HDR) begin
				if (!magic_q) begin
					fire = 1'b1;
					code = ST_BAD_MAGIC;
				end else if (!sizes_q) begin
					fire = 1'b1;
					code = ST_BAD_SIZES;
				end else if (!ext) begin
					fire = 1'b1;
					use_done = 1'b1;
				end
			end else if (pos_q == POS_LAST_EXT) begin
				fire = 1'b1;
				use_done = 1'b1;
			end
			if (!fire && eof) begin
				fire = 1'b1;
				code = (pos_q < POS_LAST_HDR) ? ST_SHORT : ST_NO_EXT;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (use_done && dims_bad) begin
			res_d.status = ST_BAD_DIMS;
		end else if (use_done) begin
			res_d.status = ST_OK;
			res_d.image_width = width_q[16:0];
			res_d.image_height = height_q[16:0];
			res_d.volume_depth = (depth_q != 32'd0) ? depth_q : 32'sd1;
			res_d.mip_levels = (mips_q == 32'd0 || mips_q[31]) ? 31'd1 : mips_q[30:0];
			res_d.array_layers = (ext && array_q != 32'd0) ? array_q : 32'sd1;
			res_d.cube_map = caps_q[0] || (ext && cube_misc_q);
			res_d.volume_texture = caps_q[1];
			res_d.extended_header = ext;
			res_d.format_code = ext ? dxgi_q : (fcc_flag_q ? fourcc_q : 32'd0);
			if (ext) begin
				res_d.bits_per_pixel = {24'd0, bpp_dxgi(dxgi_q)};
			end else if (fcc_flag_q) begin
				res_d.bits_per_pixel = {24'd0, bpp_fourcc(fourcc_q)};
			end else begin
				res_d.bits_per_pixel = bit_count_q;
			end
			res_d.srgb = ext && is_srgb(dxgi_q);
		end else begin
			res_d.status = code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			given_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept && fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				if (eof) begin
					pos_q <= '0;
					given_q <= 1'b0;
				end else begin
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 6'd1;
					end
					if (fire) begin
						given_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fire) begin
			res_q <= res_d;
		end
		if (accept && !given_q) begin
			case (pos_q)
				POS_MAGIC: magic_q <= (w == MAGIC_DDS);
				POS_HDR_SIZE: sizes_q <= (w == HDR_SIZE);
				POS_HEIGHT: height_q <= w;
				POS_WIDTH: width_q <= w;
				POS_DEPTH: depth_q <= w;
				POS_MIPS: mips_q <= w;
				POS_PF_SIZE: sizes_q <= sizes_q && (w == PF_SIZE);
				POS_PF_FLAGS: fcc_flag_q <= w[2];
				POS_FOURCC: fourcc_q <= w;
				POS_BIT_COUNT: bit_count_q <= w;
				POS_CAPS2: caps_q <= {w[21], w[9]};
				POS_DXGI: dxgi_q <= w;
				POS_MISC: cube_misc_q <= w[2];
				POS_ARRAY: array_q <= w;
				default: ;
			endcase
		end
	end

	// A word beat arriving after the result of its file can never raise another result.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && given_q) |=> !($rose(res_valid_q)))
		else $error("second result raised within one file");

	// The end_of_file beat rearms the parser.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eof) |=> (pos_q == POS_MAGIC) && !given_q)
		else $error("parser not rearmed after end of file");

	// The word counter saturates rather than wrapping back to the magic position.
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !eof && pos_q == POS_MAX) |=> (pos_q == POS_MAX))
		else $error("word position wrapped");

	// A successful result always carries usable dimensions.
	a_ok_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_OK) |->
		(res_q.image_width != 17'd0) && (res_q.image_height != 17'd0) &&
		(res_q.mip_levels != 31'd0))
		else $error("successful result with zero dimension");

	// Every failure reports zero geometry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_OK) |->
		(res_q.image_width == 17'd0) && (res_q.mip_levels == 31'd0) &&
		(res_q.format_code == 32'd0) && !res_q.extended_header)
		else $error("failure result carries non-zero fields");

endmodule
